// File: hdl/mfpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpg_pkg
// shared types and constants of the memory fill pattern generator
// ----------------------------------------------------------------------------
package mfpg_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned HALF_W    = WORD_W / 2;
  localparam int unsigned MIX_SHIFT = 33;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] LCG_MUL = 64'd6364136223846793005;
  localparam logic [WORD_W-1:0] LCG_ADD = 64'd1442695040888963407;
  localparam logic [WORD_W-1:0] MIX_MUL = 64'hff51afd7ed558ccd;
  localparam logic [WORD_W-1:0] GOLDEN  = 64'h9E3779B97F4A7C15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_BYTE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED        = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LCG_PP,
    ST_LCG_PROD,
    ST_LCG_ADD,
    ST_MIX_PP,
    ST_MIX_PROD,
    ST_MIX_OUT,
    ST_FIX_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // item taken this cycle
    logic mix_sel;    // multiplier works on the finalizer operand
    logic pp_en;      // capture partial products
    logic prod_en;    // capture combined product
    logic state_en;   // generator state takes product plus increment
    logic out_load;   // load the output register
    logic out_fixed;  // output register takes the repeated fill byte
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic random_mode;
  } status_t;

endpackage

// File: hdl/memory_fill_pattern_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_fill_pattern_generator_top
// 64-bit fill words: repeated byte, or lcg state with a murmur-style finalizer
// ----------------------------------------------------------------------------
// usage
// - each item on the slave stream (s_tdata bit 0 = restart) asks for one fill
//   word; the word leaves on the master stream, byte 0 in m_tdata[7:0]
// - restart reloads the generator state from seed xor golden ratio before
//   this word's step
// - configuration: cfg_we with cfg_index 0 random_mode, 1 fill_byte, 2 seed;
//   write only while idle; writing seed leaves the state alone
// - random mode: after accept the sequencer steps through lcg partial
//   products, lcg product, lcg add, mix partial products, mix product and
//   mix out, which loads the output register; the state update and the
//   finalizer each run through the shared 64 x 64 multiplier (three 32 x 32
//   partial products, then a combine stage), then an add or xor stage
// - fixed mode: after accept the fixed-output step loads the output register
// - one item is in work at a time; the output register holds a finished word
//   while the next item is already accepted and computed
// - a stalled receiver holds m_tvalid and m_tdata; the sequencer waits in its
//   last step until the output register frees up
// - reset: random mode, fill byte 0, seed 0, state = golden ratio constant,
//   no word pending
// ----------------------------------------------------------------------------
module memory_fill_pattern_generator_top (
  input  logic                              clk,
  input  logic                              rst,
  // slave stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,    // [0] restart, rest zero
  // master stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mfpg_pkg::WORD_W-1:0]       m_tdata,    // [63:0] fill_word
  // configuration writes
  input  logic                              cfg_we,
  input  logic [mfpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mfpg_pkg::WORD_W-1:0]       cfg_data
);

  mfpg_pkg::cmd_t    cmd;
  mfpg_pkg::status_t status;

  // sequencer
  mfpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // registers, generator state and arithmetic
  mfpg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (s_tdata[0]),
    .cmd       (cmd),
    .status    (status),
    .fill_word (m_tdata)
  );

endmodule

// File: hdl/mfpg_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpg_mul
// 64 x 64 multiply modulo 2^64 from three 32 x 32 partial products, two stages
// ----------------------------------------------------------------------------
module mfpg_mul (
  input  logic                          clk,
  input  logic [mfpg_pkg::WORD_W-1:0]   a,
  input  logic [mfpg_pkg::WORD_W-1:0]   b,
  input  logic                          pp_en,
  input  logic                          prod_en,
  output logic [mfpg_pkg::WORD_W-1:0]   prod
);

  localparam int unsigned H = mfpg_pkg::HALF_W;

  logic [mfpg_pkg::WORD_W-1:0] pp_ll;
  logic [H-1:0]                pp_hl;
  logic [H-1:0]                pp_lh;
  logic [mfpg_pkg::WORD_W-1:0] ll_next;
  logic [H-1:0]                hl_full;
  logic [H-1:0]                lh_full;
  logic [H-1:0]                mid;

  // low x low keeps the full 64-bit product, cross terms only their low halves
  assign ll_next = {{H{1'b0}}, a[H-1:0]} * {{H{1'b0}}, b[H-1:0]};
  assign hl_full = a[2*H-1:H] * b[H-1:0];
  assign lh_full = a[H-1:0] * b[2*H-1:H];
  assign mid     = pp_hl + pp_lh;

  always_ff @(posedge clk) begin
    if (pp_en) begin
      pp_ll <= ll_next;
      pp_hl <= hl_full;
      pp_lh <= lh_full;
    end
    if (prod_en) begin
      prod <= pp_ll + {mid, {H{1'b0}}};
    end
  end

endmodule

// File: hdl/mfpg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpg_dp
// configuration registers, generator state, multiplier and output register
// ----------------------------------------------------------------------------
module mfpg_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mfpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mfpg_pkg::WORD_W-1:0]         cfg_data,
  input  logic                                restart,
  input  mfpg_pkg::cmd_t                      cmd,
  output mfpg_pkg::status_t                   status,
  output logic [mfpg_pkg::WORD_W-1:0]         fill_word
);

  localparam int unsigned W = mfpg_pkg::WORD_W;

  logic         random_mode;
  logic [7:0]   fill_byte;
  logic [W-1:0] seed;
  logic [W-1:0] gen_state;
  logic [W-1:0] mix_in;
  logic [W-1:0] mul_a;
  logic [W-1:0] mul_b;
  logic [W-1:0] prod;
  logic [W-1:0] mix_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      random_mode <= 1'b1;
      fill_byte   <= '0;
      seed        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mfpg_pkg::CFG_RANDOM_MODE: random_mode <= cfg_data[0];
        mfpg_pkg::CFG_FILL_BYTE:   fill_byte   <= cfg_data[7:0];
        mfpg_pkg::CFG_SEED:        seed        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= mfpg_pkg::GOLDEN;
    end else if (cmd.accept && restart) begin
      gen_state <= seed ^ mfpg_pkg::GOLDEN;
    end else if (cmd.state_en) begin
      gen_state <= prod + mfpg_pkg::LCG_ADD;
    end
  end

  assign mix_in = gen_state ^ (gen_state >> mfpg_pkg::MIX_SHIFT);
  assign mul_a  = cmd.mix_sel ? mix_in : gen_state;
  assign mul_b  = cmd.mix_sel ? mfpg_pkg::MIX_MUL : mfpg_pkg::LCG_MUL;

  mfpg_mul u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .pp_en   (cmd.pp_en),
    .prod_en (cmd.prod_en),
    .prod    (prod)
  );

  assign mix_word = prod ^ (prod >> mfpg_pkg::MIX_SHIFT);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fill_word <= cmd.out_fixed ? {8{fill_byte}} : mix_word;
    end
  end

  assign status.random_mode = random_mode;

endmodule

// File: hdl/mfpg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpg_ctrl
// sequencer for one item at a time and output valid flag
// ----------------------------------------------------------------------------
module mfpg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  mfpg_pkg::status_t  status,
  output mfpg_pkg::cmd_t     cmd
);

  mfpg_pkg::state_t state;
  mfpg_pkg::state_t state_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == mfpg_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mfpg_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      mfpg_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.random_mode ? mfpg_pkg::ST_LCG_PP : mfpg_pkg::ST_FIX_OUT;
        end
      end
      mfpg_pkg::ST_LCG_PP: begin
        cmd.pp_en  = 1'b1;
        state_next = mfpg_pkg::ST_LCG_PROD;
      end
      mfpg_pkg::ST_LCG_PROD: begin
        cmd.prod_en = 1'b1;
        state_next  = mfpg_pkg::ST_LCG_ADD;
      end
      mfpg_pkg::ST_LCG_ADD: begin
        cmd.state_en = 1'b1;
        state_next   = mfpg_pkg::ST_MIX_PP;
      end
      mfpg_pkg::ST_MIX_PP: begin
        cmd.mix_sel = 1'b1;
        cmd.pp_en   = 1'b1;
        state_next  = mfpg_pkg::ST_MIX_PROD;
      end
      mfpg_pkg::ST_MIX_PROD: begin
        cmd.prod_en = 1'b1;
        state_next  = mfpg_pkg::ST_MIX_OUT;
      end
      mfpg_pkg::ST_MIX_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = mfpg_pkg::ST_IDLE;
        end
      end
      mfpg_pkg::ST_FIX_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_fixed = 1'b1;
          state_next    = mfpg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mfpg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/mfpg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpg_checker
// port-level checks of the fill pattern generator, bound to the top level
// ----------------------------------------------------------------------------
module mfpg_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [7:0]                        s_tdata,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [mfpg_pkg::WORD_W-1:0]       m_tdata,
  input logic                              cfg_we,
  input logic [mfpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [mfpg_pkg::WORD_W-1:0]       cfg_data
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  // one item in work: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while busy");

  // nothing pending after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a new word never appears on the cycle after an accept
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("output word too early after accept");

endmodule

bind memory_fill_pattern_generator_top mfpg_checker u_mfpg_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tdata   (s_tdata),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

// File: test/tb_memory_fill_pattern_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_memory_fill_pattern_generator_top
// self-checking bench for the memory fill pattern generator: restart requests
// go in on the slave stream, fill words are predicted from the register
// settings and the lcg state, and each word on the master stream is compared
// in order, with random idling on both streams and register changes between
// phases
// ----------------------------------------------------------------------------

// predicts fill words and holds the ones still owed by the block
class fill_word_predictor;
  bit          random_mode;
  logic [7:0]  fill_byte;
  logic [63:0] seed;
  logic [63:0] lcg_state;
  logic [63:0] pending_words[$];
  int          mismatches;

  function new();
    random_mode = 1'b1;
    fill_byte   = 8'h00;
    seed        = 64'h0;
    lcg_state   = seed ^ mfpg_pkg::GOLDEN;
    mismatches  = 0;
  endfunction

  // register write as the block sees it; an unused index changes nothing
  function void write_reg(logic [mfpg_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
    case (idx)
      mfpg_pkg::CFG_RANDOM_MODE: random_mode = value[0];
      mfpg_pkg::CFG_FILL_BYTE:   fill_byte   = value[7:0];
      mfpg_pkg::CFG_SEED:        seed        = value;
      default: ;
    endcase
  endfunction

  // one accepted request: restart reload, then lcg step and finalizer or fill byte
  function void note_request(bit restart);
    logic [63:0] word;
    if (restart)
      lcg_state = seed ^ mfpg_pkg::GOLDEN;
    if (random_mode) begin
      lcg_state = lcg_state * mfpg_pkg::LCG_MUL + mfpg_pkg::LCG_ADD;
      word = lcg_state ^ (lcg_state >> mfpg_pkg::MIX_SHIFT);
      word = word * mfpg_pkg::MIX_MUL;
      word = word ^ (word >> mfpg_pkg::MIX_SHIFT);
    end else begin
      word = {8{fill_byte}};
    end
    pending_words.push_back(word);
  endfunction

  task report(string msg);
    if (mismatches < 20)
      $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task check_word(logic [63:0] word);
    logic [63:0] want;
    if (pending_words.size() == 0) begin
      report($sformatf("fill word %h with none expected", word));
    end else begin
      want = pending_words.pop_front();
      if (word !== want)
        report($sformatf("fill word %h, expected %h", word, want));
    end
  endtask
endclass

module tb_memory_fill_pattern_generator_top;

  localparam int          RANDOM_ITEMS  = 1250;
  localparam int          QUIET_ITEMS   = 200;   // tail of the run with no idling
  localparam int          SETTLE_CYCLES = 12;    // settle wait after the last owed word is taken
  localparam int          STALL_LIMIT   = 1000;  // cycles with no item moving
  localparam logic [mfpg_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [7:0]                      s_tdata;    // [0] restart, rest zero
  logic                            m_tvalid;
  logic                            m_tready;
  logic [mfpg_pkg::WORD_W-1:0]     m_tdata;    // [63:0] fill_word
  logic                            cfg_we;
  logic [mfpg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mfpg_pkg::WORD_W-1:0]     cfg_data;

  fill_word_predictor board;
  bit                 idle_sender;
  bit                 idle_receiver;
  int                 quiet_cycles;

  memory_fill_pattern_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // one request item; an optional idle burst comes first, valid stays high after
  // acceptance so back-to-back items need no drop in between
  task automatic send_request(input bit restart);
    int gap;
    gap = 0;
    if (idle_sender && $urandom_range(0, 2) == 0)
      gap = $urandom_range(1, 14);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, restart};
    do @(posedge clk); while (!s_tready);
    board.note_request(restart);
  endtask

  // stop sending and wait until every owed word is out and the block is idle
  task automatic drain_words();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [mfpg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    board.write_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: ready runs and stall bursts, bursts only while idling is allowed
  initial begin
    int stall;
    int run;
    m_tready = 1'b0;
    forever begin
      if (idle_receiver && $urandom_range(0, 2) == 0) begin
        stall = $urandom_range(1, 14);
        repeat (stall) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
      end else begin
        run = $urandom_range(1, 12);
        repeat (run) begin
          @(negedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  // every word taken on the master stream is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_word(m_tdata);
  end

  // watchdog: too long with no item moving on either stream
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_memory_fill_pattern_generator_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          item_count;
    int          burst;
    logic [63:0] value;
    board         = new();
    quiet_cycles  = 0;
    s_tvalid      = 1'b0;
    s_tdata       = 8'h00;
    cfg_we        = 1'b0;
    cfg_index     = mfpg_pkg::CFG_RANDOM_MODE;
    cfg_data      = 64'h0;
    idle_sender   = 1'b1;
    idle_receiver = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: state starts at the golden ratio constant
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    drain_words();

    // a seed write alone leaves the running state untouched
    cfg_write(mfpg_pkg::CFG_SEED, 64'hffff_ffff_ffff_ffff);
    send_request(1'b0);
    send_request(1'b1);
    drain_words();

    // unused register index must not alias onto the mode bit
    cfg_write(CFG_UNUSED, 64'h0);
    send_request(1'b0);
    drain_words();

    // fixed mode: byte extremes and a mixed byte; restart still reloads the state
    cfg_write(mfpg_pkg::CFG_RANDOM_MODE, 64'h0);
    cfg_write(mfpg_pkg::CFG_FILL_BYTE, 64'hffff_ffff_ffff_ffff);
    send_request(1'b0);
    send_request(1'b1);
    drain_words();
    cfg_write(mfpg_pkg::CFG_FILL_BYTE, 64'h0);
    send_request(1'b0);
    drain_words();
    cfg_write(mfpg_pkg::CFG_FILL_BYTE, 64'h1234_5678_9abc_dea5);
    send_request(1'b0);
    drain_words();

    // back to random: state comes from the restart taken in fixed mode
    cfg_write(mfpg_pkg::CFG_RANDOM_MODE, 64'hffff_ffff_ffff_fffe);
    cfg_write(mfpg_pkg::CFG_RANDOM_MODE, 64'h1);
    cfg_write(mfpg_pkg::CFG_SEED, 64'h0);
    send_request(1'b0);
    send_request(1'b1);
    drain_words();

    // seed equal to the golden ratio constant restarts from a zero state
    cfg_write(mfpg_pkg::CFG_SEED, mfpg_pkg::GOLDEN);
    send_request(1'b1);
    send_request(1'b0);
    drain_words();

    // random phases, each with its own settings and idling mix
    item_count = 0;
    while (item_count < RANDOM_ITEMS) begin
      if (item_count >= RANDOM_ITEMS - QUIET_ITEMS) begin
        idle_sender   = 1'b0;
        idle_receiver = 1'b0;
      end else begin
        idle_sender   = $urandom_range(0, 3) != 0;
        idle_receiver = $urandom_range(0, 3) != 0;
      end

      if ($urandom_range(0, 3) != 0)
        cfg_write(mfpg_pkg::CFG_RANDOM_MODE, {$urandom, $urandom});
      if ($urandom_range(0, 3) != 0) begin
        value = {$urandom, $urandom};
        case ($urandom_range(0, 3))
          0:       value[7:0] = 8'h00;
          1:       value[7:0] = 8'hff;
          default: ;
        endcase
        cfg_write(mfpg_pkg::CFG_FILL_BYTE, value);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0:       value = 64'h0;
          1:       value = 64'hffff_ffff_ffff_ffff;
          2:       value = mfpg_pkg::GOLDEN;
          default: value = {$urandom, $urandom};
        endcase
        cfg_write(mfpg_pkg::CFG_SEED, value);
      end
      if ($urandom_range(0, 7) == 0)
        cfg_write(CFG_UNUSED, {$urandom, $urandom});

      burst = $urandom_range(8, 60);
      repeat (burst) begin
        send_request($urandom_range(0, 7) == 0);
        item_count++;
      end
      drain_words();
    end

    if (board.pending_words.size() != 0)
      board.report($sformatf("%0d fill words never came", board.pending_words.size()));
    if (board.mismatches == 0) begin
      $display("tb_memory_fill_pattern_generator_top passed");
    end else begin
      $display("tb_memory_fill_pattern_generator_top failed");
    end
    $finish;
  end

endmodule
